// File: hdl/gmd_pkg.sv
// shared types and constants for the grid max descent path sum block
// no dependencies; used by every module under hdl/
package gmd_pkg;

	localparam int SUM_BITS      = 23;
	localparam int REG_BITS      = 8;
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// register index, taken from paddr[2]
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef logic [SUM_BITS-1:0] sum_t;
	typedef logic [REG_BITS-1:0] size_reg_t;

	localparam sum_t SUM_MAX = '1;

	// per accepted cell: grid finished, and its best final-row sum
	typedef struct packed {
		logic done;
		sum_t best;
	} sweep_res_t;

endpackage

// File: hdl/grid_max_descent_path_sum.sv
// latency: best_sum is presented the cycle after the grid's last cell beat is taken
// throughput: one cell per cycle over rows and grids unless stalled; the buffer does
//   one write, at most one look-ahead read per cell; row wrap reloads from registers
// reset: arst_n clears counters, window and output valid; sizes return to 1x1;
//   the row buffer itself is not cleared
module grid_max_descent_path_sum #(
	parameter int MAX_ROWS   = 128,
	parameter int MAX_COLS   = 128,
	parameter int VALUE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,  // cell_value
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,  // best_sum
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gmd_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [gmd_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [gmd_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RSW = $clog2(MAX_ROWS+1);
	localparam int CSW = $clog2(MAX_COLS+1);

	logic [RSW-1:0]      rows_eff;
	logic [CSW-1:0]      cols_eff;
	logic                fire;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	gmd_pkg::sum_t       mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	gmd_pkg::sum_t       mem_rdata;
	gmd_pkg::sweep_res_t res;
	logic                out_valid_q;
	gmd_pkg::sum_t       out_sum_q;

	assign pready   = 1'b1;
	assign s_tready = !out_valid_q || m_tready;
	assign fire     = s_tvalid && s_tready;

	gmd_cfg_regs #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.rows_eff (rows_eff),
		.cols_eff (cols_eff)
	);

	gmd_row_mem #(
		.DEPTH (MAX_COLS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gmd_sweep #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.value     (s_tdata[VALUE_BITS-1:0]),
		.rows_eff  (rows_eff),
		.cols_eff  (cols_eff),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (res)
	);

	// output register; a new result may load in the cycle the old one is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done)
			out_sum_q <= res.best;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_sum_q};

endmodule

// File: hdl/gmd_cfg_regs.sv
// apb size registers and their clamped effective values
// depends on gmd_pkg
module gmd_cfg_regs #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gmd_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [gmd_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [gmd_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic [$clog2(MAX_ROWS+1)-1:0]       rows_eff,
	output logic [$clog2(MAX_COLS+1)-1:0]       cols_eff
);

	localparam int RSW = $clog2(MAX_ROWS+1);
	localparam int CSW = $clog2(MAX_COLS+1);
	localparam int RXW = (RSW > gmd_pkg::REG_BITS) ? RSW : gmd_pkg::REG_BITS;
	localparam int CXW = (CSW > gmd_pkg::REG_BITS) ? CSW : gmd_pkg::REG_BITS;

	gmd_pkg::size_reg_t rows_q;
	gmd_pkg::size_reg_t cols_q;
	logic               wr_en;
	logic               reg_sel;

	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gmd_pkg::size_reg_t'(1);
			cols_q <= gmd_pkg::size_reg_t'(1);
		end else if (wr_en) begin
			case (reg_sel)
				gmd_pkg::REG_ROWS: rows_q <= pwdata[gmd_pkg::REG_BITS-1:0];
				gmd_pkg::REG_COLS: cols_q <= pwdata[gmd_pkg::REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			gmd_pkg::REG_ROWS: prdata = gmd_pkg::APB_DATA_BITS'(rows_q);
			gmd_pkg::REG_COLS: prdata = gmd_pkg::APB_DATA_BITS'(cols_q);
			default:           prdata = '0;
		endcase
	end

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (rows_q == '0)
			rows_eff = RSW'(1);
		else if (RXW'(rows_q) > RXW'(MAX_ROWS))
			rows_eff = RSW'(MAX_ROWS);
		else
			rows_eff = RSW'(rows_q);

		if (cols_q == '0)
			cols_eff = CSW'(1);
		else if (CXW'(cols_q) > CXW'(MAX_COLS))
			cols_eff = CSW'(MAX_COLS);
		else
			cols_eff = CSW'(cols_q);
	end

endmodule

// File: hdl/gmd_row_mem.sv
// one-row buffer of best partial sums: one write port, one registered read port
// depends on gmd_pkg
module gmd_row_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  gmd_pkg::sum_t     wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output gmd_pkg::sum_t     rdata
);

	gmd_pkg::sum_t mem [DEPTH];
	gmd_pkg::sum_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/gmd_sweep.sv
// row sweep: position counters, three-entry neighbor window, update and row max
// depends on gmd_pkg; drives the row buffer in gmd_row_mem
module gmd_sweep #(
	parameter int MAX_ROWS   = 128,
	parameter int MAX_COLS   = 128,
	parameter int VALUE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  fire,
	input  logic [VALUE_BITS-1:0]                 value,
	input  logic [$clog2(MAX_ROWS+1)-1:0]         rows_eff,
	input  logic [$clog2(MAX_COLS+1)-1:0]         cols_eff,
	output logic                                  mem_we,
	output logic [(MAX_COLS>1 ? $clog2(MAX_COLS) : 1)-1:0] mem_waddr,
	output gmd_pkg::sum_t                         mem_wdata,
	output logic                                  mem_re,
	output logic [(MAX_COLS>1 ? $clog2(MAX_COLS) : 1)-1:0] mem_raddr,
	input  gmd_pkg::sum_t                         mem_rdata,
	output gmd_pkg::sweep_res_t                   res
);

	localparam int AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CSW  = $clog2(MAX_COLS+1);
	localparam int RSW  = $clog2(MAX_ROWS+1);
	localparam int CCW  = ((AW + 1) > CSW) ? (AW + 1) : CSW;
	localparam int RCW  = ((RW + 1) > RSW) ? (RW + 1) : RSW;
	localparam int RAW  = AW + 2;
	localparam int XW   = ((VALUE_BITS > gmd_pkg::SUM_BITS) ? VALUE_BITS
	                                                        : gmd_pkg::SUM_BITS) + 1;

	logic [AW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	gmd_pkg::sum_t  lft_q;
	gmd_pkg::sum_t  ctr_q;
	gmd_pkg::sum_t  rgt_q;
	logic           rd_pend_q;
	gmd_pkg::sum_t  first0_q;
	gmd_pkg::sum_t  first1_q;
	gmd_pkg::sum_t  run_q;

	logic [CCW-1:0] col_inc;
	logic [RCW-1:0] row_inc;
	logic [RAW-1:0] rd_addr;
	logic           last_col;
	logic           last_row;
	logic           col_zero;
	logic           col_one;
	gmd_pkg::sum_t  rgt_cur;
	gmd_pkg::sum_t  left_nb;
	gmd_pkg::sum_t  right_nb;
	gmd_pkg::sum_t  max_lc;
	gmd_pkg::sum_t  best_above;
	logic [XW-1:0]  sum_w;
	gmd_pkg::sum_t  fresh;
	gmd_pkg::sum_t  run_next;

	assign col_inc  = CCW'(col_q) + CCW'(1);
	assign row_inc  = RCW'(row_q) + RCW'(1);
	assign last_col = col_inc >= CCW'(cols_eff);
	assign last_row = row_inc >= RCW'(rows_eff);
	assign col_zero = col_q == '0;
	assign col_one  = col_q == AW'(1);

	// right neighbor comes straight from the read port in the cycle after the read
	assign rgt_cur  = rd_pend_q ? mem_rdata : rgt_q;
	assign left_nb  = col_zero ? '0 : lft_q;
	assign right_nb = last_col ? '0 : rgt_cur;
	assign max_lc   = (left_nb > ctr_q) ? left_nb : ctr_q;

	always_comb begin
		if (row_q == '0)
			best_above = '0;
		else
			best_above = (max_lc > right_nb) ? max_lc : right_nb;
	end

	assign sum_w    = XW'(value) + XW'(best_above);
	assign fresh    = (sum_w > XW'(gmd_pkg::SUM_MAX)) ? gmd_pkg::SUM_MAX
	                                                  : sum_w[gmd_pkg::SUM_BITS-1:0];
	assign run_next = (col_zero || fresh > run_q) ? fresh : run_q;

	// fetch the entry two columns ahead; the row wrap refills from first0/first1
	assign rd_addr   = RAW'(col_q) + RAW'(2);
	assign mem_re    = fire && !last_col && (rd_addr < RAW'(MAX_COLS));
	assign mem_raddr = rd_addr[AW-1:0];
	assign mem_we    = fire;
	assign mem_waddr = col_q;
	assign mem_wdata = fresh;

	assign res.done = fire && last_col && last_row;
	assign res.best = run_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			lft_q     <= '0;
			ctr_q     <= '0;
			rgt_q     <= '0;
			rd_pend_q <= 1'b0;
			first0_q  <= '0;
			first1_q  <= '0;
			run_q     <= '0;
		end else if (fire) begin
			run_q <= (last_col && last_row) ? '0 : run_next;
			if (col_zero)
				first0_q <= fresh;
			if (col_one)
				first1_q <= fresh;
			if (last_col) begin
				col_q     <= '0;
				row_q     <= last_row ? '0 : row_q + RW'(1);
				lft_q     <= '0;
				// the row just finished becomes the row above
				ctr_q     <= col_zero ? fresh : first0_q;
				rgt_q     <= col_one ? fresh : first1_q;
				rd_pend_q <= 1'b0;
			end else begin
				col_q     <= col_inc[AW-1:0];
				lft_q     <= ctr_q;
				ctr_q     <= rgt_cur;
				rd_pend_q <= mem_re;
			end
		end else if (rd_pend_q) begin
			rgt_q     <= mem_rdata;
			rd_pend_q <= 1'b0;
		end
	end

	// read and write never meet on one entry, so the buffer needs no bypass
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("row buffer read and write hit the same entry");

	a_wrap_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_col) |=> (!rd_pend_q && col_q == '0))
		else $error("row wrap left a read outstanding or column nonzero");

	a_pend_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rd_pend_q) |-> $past(mem_re))
		else $error("read pending without a read issued");

	a_done_resets_row: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> (row_q == '0 && run_q == '0))
		else $error("grid end did not restart the sweep");

endmodule
